// File: rtl/core/ttcs_pkg.sv
// shared types and constants for the text terminal cursor and scroll engine
`timescale 1ns / 1ps
`default_nettype none

package ttcs_pkg;

    // command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // character and cell constants
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [15:0] BLANK_CELL   = 16'h0720;
    localparam logic [7:0]  ATTR_RESET   = 8'h07;
    localparam int          ROW_RESET    = 2;

    // control word for the shared index walker
    typedef struct packed {
        logic load;
        logic step;
    } t_walk_cmd;

endpackage

`default_nettype wire

// File: rtl/core/ttcs_cell_ram.sv
// single write, single registered read cell store
`timescale 1ns / 1ps
`default_nettype none

module ttcs_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/ttcs_walker.sv
// shared index walker: one incrementer and one end compare for all sweeps
`timescale 1ns / 1ps
`default_nettype none

module ttcs_walker #(
    parameter int AW = 11,
    parameter int RESET_LIMIT = 1999
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ttcs_pkg::t_walk_cmd i_cmd,
    input  wire logic [AW-1:0]      i_start_idx,
    input  wire logic [AW-1:0]      i_limit,
    output logic      [AW-1:0]      o_idx,
    output logic                    o_last
);

    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_limit, n_limit;

    // next index and limit
    always_comb begin
        n_idx   = r_idx;
        n_limit = r_limit;
        if (i_cmd.load) begin
            n_idx   = i_start_idx;
            n_limit = i_limit;
        end else if (i_cmd.step) begin
            n_idx = r_idx + AW'(1);
        end
    end

    // reset starts the power-up clearing sweep from zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_limit <= AW'(RESET_LIMIT);
        end else begin
            r_idx   <= n_idx;
            r_limit <= n_limit;
        end
    end

    assign o_idx  = r_idx;
    assign o_last = (r_idx == r_limit);

endmodule

`default_nettype wire

// File: rtl/core/text_terminal_cursor_scroll.sv
// top level: command sequencer, cursor and attribute registers of the text terminal
//
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+---------------------------
//  command   | i_command i_char_code i_read_row i_read_col        | i_start high, o_busy low
//  result    | o_cell_value o_cursor_row o_cursor_col             | o_valid, one cycle
//  config    | i_cfg_wdata (text attribute)                       | i_cfg_we
//
// after reset the store is swept to blank, one cell a cycle, with o_busy high
// a read passes through S_READ and S_RDATA, a put through S_PUT, a put that scrolls
// then through S_SCROLL and S_FILL, and a clear through S_CLEAR
// scroll streams the store through its registered read port, one cell a cycle
// the result shows for one cycle the cycle after the command finishes; the
// receiver cannot stall it
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [4:0]  i_read_row,
    input  wire logic [6:0]  i_read_col,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    output logic             o_valid,
    output logic      [15:0] o_cell_value,
    output logic      [4:0]  o_cursor_row,
    output logic      [6:0]  o_cursor_col
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);

    // sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_RDATA  = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_SCROLL = 3'd6;
    localparam logic [2:0] S_FILL   = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [7:0]    r_attr;
    logic [7:0]    r_char, n_char;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_wr_ok, n_wr_ok;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    logic          r_drain, n_drain;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_cell, n_out_cell;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [CW-1:0] r_out_col, n_out_col;

    ttcs_pkg::t_walk_cmd walk_cmd;
    logic [AW-1:0] walk_start, walk_limit, walk_idx;
    logic          walk_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic          is_nl, wrap, scroll;
    logic [CW-1:0] col_inc;
    logic [RW-1:0] row_inc;
    logic          rd_in_range;
    logic [AW-1:0] cur_addr, rd_addr;

    // cell store
    ttcs_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared sweep index
    ttcs_walker #(
        .AW          (AW),
        .RESET_LIMIT (CELLS - 1)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (walk_cmd),
        .i_start_idx (walk_start),
        .i_limit     (walk_limit),
        .o_idx       (walk_idx),
        .o_last      (walk_last)
    );

    // linear addresses of the cursor cell and the read cell
    assign cur_addr = AW'(32'(r_row) * COLUMNS + 32'(r_col));
    assign rd_addr  = AW'(32'(i_read_row) * COLUMNS + 32'(i_read_col));
    assign rd_in_range = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);

    // cursor advance for a put
    assign is_nl   = (r_char == ttcs_pkg::NEWLINE_CODE);
    assign col_inc = r_col + CW'(1);
    assign row_inc = r_row + RW'(1);
    assign wrap    = is_nl || (col_inc >= CW'(COLUMNS));
    assign scroll  = wrap && (row_inc >= RW'(ROWS));

    // store port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = walk_idx;
        ram_wdata = ttcs_pkg::BLANK_CELL;
        ram_raddr = r_addr;
        case (r_state)
            S_INIT, S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_PUT: begin
                ram_we    = !is_nl && r_wr_ok;
                ram_waddr = r_addr;
                ram_wdata = {r_attr, r_char};
            end
            S_SCROLL: begin
                ram_we    = r_pend;
                ram_waddr = r_pend_addr;
                ram_wdata = ram_rdata;
                ram_raddr = walk_idx;
            end
            S_FILL: begin
                if (r_drain) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr;
                    ram_wdata = ram_rdata;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = {r_attr, ttcs_pkg::SPACE_CODE};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_char      = r_char;
        n_addr      = r_addr;
        n_wr_ok     = r_wr_ok;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_drain     = r_drain;
        n_out_valid = 1'b0;
        n_out_cell  = r_out_cell;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        walk_cmd    = '0;
        walk_start  = '0;
        walk_limit  = AW'(CELLS - 1);
        case (r_state)
            S_INIT: begin
                walk_cmd.step = 1'b1;
                if (walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        ttcs_pkg::CMD_PUT: begin
                            n_char  = i_char_code;
                            n_addr  = cur_addr;
                            n_wr_ok = (r_row < RW'(ROWS));
                            n_state = S_PUT;
                        end
                        ttcs_pkg::CMD_CLEAR: begin
                            walk_cmd.load = 1'b1;
                            n_state       = S_CLEAR;
                        end
                        ttcs_pkg::CMD_READ: begin
                            if (rd_in_range) begin
                                n_addr  = rd_addr;
                                n_state = S_READ;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_cell  = '0;
                                n_out_row   = r_row;
                                n_out_col   = r_col;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_cell  = '0;
                            n_out_row   = r_row;
                            n_out_col   = r_col;
                        end
                    endcase
                end
            end
            S_PUT: begin
                n_col  = wrap ? '0 : col_inc;
                n_row  = scroll ? RW'(ROWS - 1) : (wrap ? row_inc : r_row);
                n_pend = 1'b0;
                if (scroll) begin
                    walk_cmd.load = 1'b1;
                    walk_start    = AW'(COLUMNS);
                    walk_limit    = AW'(CELLS - 1);
                    n_state       = S_SCROLL;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_cell  = '0;
                    n_out_row   = n_row;
                    n_out_col   = n_col;
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_out_valid = 1'b1;
                n_out_cell  = ram_rdata;
                n_out_row   = r_row;
                n_out_col   = r_col;
                n_state     = S_IDLE;
            end
            S_CLEAR: begin
                walk_cmd.step = 1'b1;
                if (walk_last) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = '0;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    n_state     = S_IDLE;
                end
            end
            S_SCROLL: begin
                // read one row below, write it back in the next cycle
                n_pend      = 1'b1;
                n_pend_addr = walk_idx - AW'(COLUMNS);
                if (walk_last) begin
                    walk_cmd.load = 1'b1;
                    walk_start    = AW'(CELLS - COLUMNS);
                    walk_limit    = AW'(CELLS - 1);
                    n_drain       = 1'b1;
                    n_state       = S_FILL;
                end else begin
                    walk_cmd.step = 1'b1;
                end
            end
            S_FILL: begin
                // first drains the last moved cell, then blanks the bottom row
                if (r_drain) begin
                    n_drain = 1'b0;
                    n_pend  = 1'b0;
                end else begin
                    walk_cmd.step = 1'b1;
                    if (walk_last) begin
                        n_out_valid = 1'b1;
                        n_out_cell  = '0;
                        n_out_row   = r_row;
                        n_out_col   = r_col;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= RW'(ttcs_pkg::ROW_RESET);
            r_col       <= '0;
            r_pend      <= 1'b0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pend      <= n_pend;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ttcs_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char      <= n_char;
        r_addr      <= n_addr;
        r_wr_ok     <= n_wr_ok;
        r_pend_addr <= n_pend_addr;
        r_out_cell  <= n_out_cell;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
    end

    // result word and handshake
    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_cell_value = r_out_cell;
    assign o_cursor_row = 5'(r_out_row);
    assign o_cursor_col = 7'(r_out_col);

endmodule

`default_nettype wire

// File: bench/text_terminal_cursor_scroll_tb.sv
// self-checking testbench for the text terminal cursor and scroll engine
`timescale 1ns / 1ps

module text_terminal_cursor_scroll_tb;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = ROWS * COLUMNS;
    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_WORDS = 290;
    localparam int CFG_INTERVAL = 70;
    // slowest legal run: every word a full store walk plus the longest sender gap
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  row;
        logic [6:0]  col;
    } t_cursor_report;

    // shadow copy of the screen and cursor, plus the queue of reports still owed
    class screen_tracker;
        logic [15:0]    cells [CELLS];
        int             cursor_row;
        int             cursor_col;
        logic [7:0]     attr;
        t_cursor_report pending_reports [$];
        int             fail_count;

        function void power_on();
            foreach (cells[i]) cells[i] = ttcs_pkg::BLANK_CELL;
            cursor_row = ttcs_pkg::ROW_RESET;
            cursor_col = 0;
            attr       = ttcs_pkg::ATTR_RESET;
            fail_count = 0;
        endfunction

        // line feed, scrolling the screen when it runs off the bottom
        function void advance_row();
            cursor_col = 0;
            cursor_row++;
            if (cursor_row >= ROWS) begin
                for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                    cells[i] = {attr, ttcs_pkg::SPACE_CODE};
                cursor_row = ROWS - 1;
            end
        endfunction

        function void note_command(logic [1:0] cmd, logic [7:0] ch,
                                   logic [4:0] rr, logic [6:0] rc);
            t_cursor_report rep;
            rep.cell_value = '0;
            case (cmd)
                ttcs_pkg::CMD_PUT: begin
                    if (ch == ttcs_pkg::NEWLINE_CODE) begin
                        advance_row();
                    end else begin
                        if (cursor_row < ROWS && cursor_col < COLUMNS)
                            cells[cursor_row * COLUMNS + cursor_col] = {attr, ch};
                        cursor_col++;
                        if (cursor_col >= COLUMNS) advance_row();
                    end
                end
                ttcs_pkg::CMD_CLEAR: begin
                    foreach (cells[i]) cells[i] = ttcs_pkg::BLANK_CELL;
                end
                ttcs_pkg::CMD_READ: begin
                    if (rr < ROWS && rc < COLUMNS) rep.cell_value = cells[rr * COLUMNS + rc];
                end
                default: ;
            endcase
            rep.row = cursor_row[4:0];
            rep.col = cursor_col[6:0];
            pending_reports.push_back(rep);
        endfunction

        function void check_report(logic [15:0] cell_value, logic [4:0] row, logic [6:0] col);
            t_cursor_report want;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected word: cell %h row %0d col %0d", $time,
                         cell_value, row, col);
                fail_count++;
                return;
            end
            want = pending_reports.pop_front();
            if (cell_value !== want.cell_value) begin
                $display("%0t: cell_value expected %h actual %h", $time,
                         want.cell_value, cell_value);
                fail_count++;
            end
            if (row !== want.row) begin
                $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, row);
                fail_count++;
            end
            if (col !== want.col) begin
                $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, col);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_start     = 1'b0;
    logic [1:0]  i_command   = ttcs_pkg::CMD_PUT;
    logic [7:0]  i_char_code = '0;
    logic [4:0]  i_read_row  = '0;
    logic [6:0]  i_read_col  = '0;
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        o_busy;
    logic        o_valid;
    logic [15:0] o_cell_value;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;

    screen_tracker tracker;
    int            words_sent;
    int            words_since_cfg;
    int            cycle_count;
    bit            steady;

    text_terminal_cursor_scroll #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_cell_value(o_cell_value),
        .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // monitor: check reports, then log accepted commands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) tracker.check_report(o_cell_value, o_cursor_row, o_cursor_col);
            if (i_start && !o_busy)
                tracker.note_command(i_command, i_char_code, i_read_row, i_read_col);
        end
    end

    // present one command word and hold it until the block takes it
    task automatic send_word(logic [1:0] cmd, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_command   <= cmd;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        words_sent++;
        words_since_cfg++;
    endtask

    task automatic send_put(logic [7:0] ch);
        send_word(ttcs_pkg::CMD_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    endtask

    task automatic send_read(logic [4:0] rr, logic [6:0] rc);
        send_word(ttcs_pkg::CMD_READ, 8'($urandom_range(0, 255)), rr, rc);
    endtask

    // half the time on the cursor row, else anywhere, sometimes past the screen edge
    task automatic read_somewhere();
        int pick;
        int col;
        pick = $urandom_range(0, 5);
        if (pick < 3) begin
            col = (tracker.cursor_col > 0 && pick == 0) ? tracker.cursor_col - 1
                                                        : $urandom_range(0, COLUMNS - 1);
            send_read(5'(tracker.cursor_row), 7'(col));
        end else if (pick < 5) begin
            send_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
        end else begin
            send_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        end
    endtask

    // attribute change only once the block is idle and every report is in
    task automatic write_attribute(logic [7:0] value);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (o_busy || tracker.pending_reports.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.attr = value;
        words_since_cfg = 0;
    endtask

    function automatic logic [7:0] random_glyph();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    initial begin
        int kind;
        int len;
        tracker = new();
        tracker.power_on();
        words_sent  = 0;
        cycle_count = 0;
        steady      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // directed: blank store, range edges, extreme bytes, newline, unused code
        write_attribute(8'hFF);
        send_read(5'd0, 7'd0);
        send_read(5'd24, 7'd79);
        send_read(5'd31, 7'd127);
        send_read(5'd25, 7'd0);
        send_read(5'd0, 7'd80);
        send_put(8'h00);
        send_put(8'hFF);
        send_put(8'h41);
        send_read(5'd2, 7'd0);
        send_read(5'd2, 7'd1);
        send_read(5'd2, 7'd2);
        send_put(ttcs_pkg::NEWLINE_CODE);
        send_word(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);

        // directed: zero attribute, high-bit character, clear keeps the cursor
        write_attribute(8'h00);
        send_put(8'h80);
        send_read(5'd3, 7'd0);
        send_word(ttcs_pkg::CMD_CLEAR, 8'h5A, 5'd7, 7'd9);
        send_read(5'd3, 7'd0);
        send_read(5'd0, 7'd79);
        send_read(5'd24, 7'd0);
        send_read(5'd24, 7'd79);

        // random: drive to the bottom row and wrap a full line so scrolling is certain
        write_attribute(8'($urandom_range(0, 255)));
        words_sent = 0;
        repeat (ROWS) send_put(ttcs_pkg::NEWLINE_CODE);
        repeat (COLUMNS + 3) send_put(random_glyph());
        read_somewhere();

        while (words_sent < RANDOM_WORDS) begin
            if (words_since_cfg >= CFG_INTERVAL) begin
                case ($urandom_range(0, 3))
                    0:       write_attribute(8'h00);
                    1:       write_attribute(8'hFF);
                    default: write_attribute(8'($urandom_range(0, 255)));
                endcase
            end
            steady = ($urandom_range(0, 3) == 0);
            kind   = $urandom_range(0, 19);
            if (kind < 8) begin
                // text line, now and then long enough to wrap
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(COLUMNS - 4, COLUMNS + 4)
                                                  : $urandom_range(1, 12);
                repeat (len) send_put(random_glyph());
                if ($urandom_range(0, 1) == 1) send_put(ttcs_pkg::NEWLINE_CODE);
            end else if (kind < 15) begin
                repeat ($urandom_range(1, 4)) read_somewhere();
            end else if (kind < 18) begin
                repeat ($urandom_range(1, 8)) send_put(ttcs_pkg::NEWLINE_CODE);
            end else if (kind == 18) begin
                send_word(ttcs_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end else begin
                // noise word with arbitrary fields
                send_word(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end
        end

        // drain, then give any stray word time to show up
        i_start <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (CELLS + 8) @(posedge i_clk);
        if (tracker.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
